>>> hdl/im2col_pkg.sv
// Shared types and constants for the im2col tilized address generator.
// Holds the register index codes, the derived geometry struct and the result struct.
// No dependencies.
package im2col_pkg;

    localparam int unsigned TILE_ROW_BYTES = 64;
    localparam int unsigned TILE_ROWS      = 32;
    localparam int unsigned TILE_JUMP      = TILE_ROW_BYTES * (TILE_ROWS - 1);
    localparam int unsigned SETTLE_CYCLES  = 3;

    typedef enum logic [3:0] {
        REG_SRC_BASE_ADDR = 4'd0,
        REG_CHANNELS      = 4'd1,
        REG_IMAGE_HEIGHT  = 4'd2,
        REG_IMAGE_WIDTH   = 4'd3,
        REG_FILTER_ROWS   = 4'd4,
        REG_FILTER_COLS   = 4'd5,
        REG_STRIDE_ROWS   = 4'd6,
        REG_STRIDE_COLS   = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] src_base;
        logic [6:0]  stick;
        logic [12:0] ih;
        logic [12:0] iw;
        logic [4:0]  fr;
        logic [4:0]  fc;
        logic [4:0]  sr;
        logic [4:0]  sc;
        logic [18:0] row_pitch;
        logic [11:0] sc_stick;
        logic [23:0] sr_pitch;
        logic [30:0] img_pitch;
        logic [8:0]  ntc;
        logic [19:0] row_total;
    } derived_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        push_tiles;
        logic        image_last;
    } result_t;

endpackage

>>> hdl/im2col_tilized_address_gen.sv
// Top level of the im2col tilized address generator: handshakes and the result register.
// Depends on im2col_pkg, im2col_cfg and im2col_walk.
//
// Channel   Direction  Handshake                  Contents
// s_        in         s_tvalid / s_tready        buffer pointer, restart flag
// m_        out        m_tvalid / m_tready        source and destination address, flags
// cfg_      in         cfg_valid / cfg_ready      register index and write data
//
// A request is accepted per cycle while s_tready is high; the output register takes its result.
// The walk state update and the result are formed in the same cycle from the accepted request.
// A stalled output holds its result; a new request is taken in the cycle the result is taken.
// After reset and after every configuration write, s_tready stays low while the derived pitch
// and tile count registers settle. cfg_ready is always high.
module im2col_tilized_address_gen import im2col_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] buffer_base
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] src_addr, [63:32] dst_addr
    output logic        m_tuser,   // [0] push_tiles
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    derived_t derived;
    logic     busy;
    logic     accept;
    result_t  result;
    result_t  result_reg;
    logic     out_valid_reg, out_valid_next;

    im2col_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived),
        .busy      (busy)
    );

    im2col_walk #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .derived     (derived),
        .accept      (accept),
        .restart     (s_tuser),
        .buffer_base (s_tdata),
        .result      (result)
    );

    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        out_valid_next = accept || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.dst_addr, result_reg.src_addr};
    assign m_tuser  = result_reg.push_tiles;
    assign m_tlast  = result_reg.image_last;

    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("Requests accepted before the derived configuration settled after reset.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("Accepted request produced no result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> !s_tready)
        else $error("Request accepted while configuration was settling.");

endmodule

>>> hdl/im2col_cfg.sv
// Configuration registers and the registered pipeline that derives pitches and tile counts.
// Depends on im2col_pkg.
module im2col_cfg import im2col_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output derived_t    derived,
    output logic        busy
);

    logic [31:0] src_base_reg;
    logic [5:0]  channels_reg;
    logic [12:0] image_height_reg;
    logic [12:0] image_width_reg;
    logic [4:0]  filter_rows_reg;
    logic [4:0]  filter_cols_reg;
    logic [4:0]  stride_rows_reg;
    logic [4:0]  stride_cols_reg;
    logic [1:0]  settle_reg;

    logic [12:0] ih, iw;
    logic [4:0]  fr, fc, sr, sc;
    logic [6:0]  stick;

    logic [18:0] row_pitch_reg;
    logic [11:0] sc_stick_reg;
    logic [9:0]  ch_fr_reg;
    logic [23:0] sr_pitch_reg;
    logic [30:0] img_pitch_reg;
    logic [13:0] ntc_prod_reg;
    logic [8:0]  ntc_reg;
    logic [8:0]  ntc_next;

    assign cfg_ready = 1'b1;
    assign busy      = (settle_reg != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_base_reg     <= '0;
            channels_reg     <= 6'd32;
            image_height_reg <= 13'd1;
            image_width_reg  <= 13'd1;
            filter_rows_reg  <= 5'd1;
            filter_cols_reg  <= 5'd1;
            stride_rows_reg  <= 5'd1;
            stride_cols_reg  <= 5'd1;
            settle_reg       <= 2'(SETTLE_CYCLES);
        end else begin
            if (cfg_valid && cfg_ready) begin
                settle_reg <= 2'(SETTLE_CYCLES);
                unique case (cfg_reg_t'(cfg_index))
                    REG_SRC_BASE_ADDR: src_base_reg     <= cfg_data;
                    REG_CHANNELS:      channels_reg     <= cfg_data[5:0];
                    REG_IMAGE_HEIGHT:  image_height_reg <= cfg_data[12:0];
                    REG_IMAGE_WIDTH:   image_width_reg  <= cfg_data[12:0];
                    REG_FILTER_ROWS:   filter_rows_reg  <= cfg_data[4:0];
                    REG_FILTER_COLS:   filter_cols_reg  <= cfg_data[4:0];
                    REG_STRIDE_ROWS:   stride_rows_reg  <= cfg_data[4:0];
                    REG_STRIDE_COLS:   stride_cols_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_comb begin
        ih = (image_height_reg == '0) ? 13'd1 :
             (image_height_reg > 13'd4096) ? 13'd4096 : image_height_reg;
        iw = (image_width_reg == '0) ? 13'd1 :
             (image_width_reg > 13'd4096) ? 13'd4096 : image_width_reg;
        fr = (filter_rows_reg == '0) ? 5'd1 :
             (filter_rows_reg > 5'd16) ? 5'd16 : filter_rows_reg;
        fc = (filter_cols_reg == '0) ? 5'd1 :
             (filter_cols_reg > 5'd16) ? 5'd16 : filter_cols_reg;
        sr = (stride_rows_reg == '0) ? 5'd1 : stride_rows_reg;
        sc = (stride_cols_reg == '0) ? 5'd1 : stride_cols_reg;
        stick = {channels_reg, 1'b0};
        if (ntc_prod_reg[13:5] == '0) begin
            ntc_next = 9'd1;
        end else if (ntc_prod_reg[13:5] > 9'd256) begin
            ntc_next = 9'd256;
        end else begin
            ntc_next = ntc_prod_reg[13:5];
        end
    end

    always_ff @(posedge aclk) begin
        row_pitch_reg <= 19'(iw * stick);
        sc_stick_reg  <= 12'(sc * stick);
        ch_fr_reg     <= 10'(channels_reg * fr);
        sr_pitch_reg  <= 24'(sr * row_pitch_reg);
        img_pitch_reg <= 31'(ih * row_pitch_reg);
        ntc_prod_reg  <= 14'(ch_fr_reg * fc);
        ntc_reg       <= ntc_next;
    end

    always_comb begin
        derived.src_base  = src_base_reg;
        derived.stick     = stick;
        derived.ih        = ih;
        derived.iw        = iw;
        derived.fr        = fr;
        derived.fc        = fc;
        derived.sr        = sr;
        derived.sc        = sc;
        derived.row_pitch = row_pitch_reg;
        derived.sc_stick  = sc_stick_reg;
        derived.sr_pitch  = sr_pitch_reg;
        derived.img_pitch = img_pitch_reg;
        derived.ntc       = ntc_reg;
        derived.row_total = {ntc_reg, 11'd0};
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> busy)
        else $error("Configuration write did not start the settle interval.");

endmodule

>>> hdl/im2col_walk.sv
// Walk state of the source traversal and destination tile packing, one step per request.
// Depends on im2col_pkg.
module im2col_walk import im2col_pkg::*; #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  derived_t    derived,
    input  logic        accept,
    input  logic        restart,
    input  logic [31:0] buffer_base,
    output result_t     result
);

    logic                  started_reg;
    logic [11:0]           row_index_reg, row_index_next;
    logic [11:0]           col_index_reg, col_index_next;
    logic [3:0]            tap_row_reg, tap_row_next;
    logic [3:0]            tap_col_reg, tap_col_next;
    logic [ADDR_WIDTH-1:0] image_offset_reg, image_offset_next;
    logic [ADDR_WIDTH-1:0] win_row_addr_reg, win_row_addr_next;
    logic [ADDR_WIDTH-1:0] win_addr_reg, win_addr_next;
    logic [ADDR_WIDTH-1:0] tap_row_addr_reg, tap_row_addr_next;
    logic [ADDR_WIDTH-1:0] tap_addr_reg, tap_addr_next;
    logic [ADDR_WIDTH-1:0] wr_addr_reg, wr_addr_next;
    logic [ADDR_WIDTH-1:0] tile_row_start_reg, tile_row_start_next;
    logic [6:0]            tile_row_bytes_reg, tile_row_bytes_next;
    logic [23:0]           tiles_row_bytes_reg, tiles_row_bytes_next;
    logic [7:0]            tile_col_reg, tile_col_next;

    logic [11:0]           row_cur, col_cur;
    logic [3:0]            trow_cur, tcol_cur;
    logic [ADDR_WIDTH-1:0] io_cur, wra_cur, wa_cur, tra_cur, ta_cur, wr_cur, trs_cur;
    logic [6:0]            btr_cur;
    logic [23:0]           br_cur;
    logic [7:0]            tc_cur;
    logic [24:0]           nb;

    function automatic logic [31:0] out32(input logic [ADDR_WIDTH-1:0] a);
        logic [63:0] w;
        w = 64'(a);
        return w[31:0];
    endfunction

    always_comb begin
        if (restart || !started_reg) begin
            row_cur  = '0;
            col_cur  = '0;
            trow_cur = '0;
            tcol_cur = '0;
            io_cur   = '0;
            wra_cur  = '0;
            wa_cur   = '0;
            tra_cur  = '0;
            ta_cur   = '0;
            wr_cur   = '0;
            trs_cur  = '0;
            btr_cur  = '0;
            br_cur   = '0;
            tc_cur   = '0;
        end else begin
            row_cur  = row_index_reg;
            col_cur  = col_index_reg;
            trow_cur = tap_row_reg;
            tcol_cur = tap_col_reg;
            io_cur   = image_offset_reg;
            wra_cur  = win_row_addr_reg;
            wa_cur   = win_addr_reg;
            tra_cur  = tap_row_addr_reg;
            ta_cur   = tap_addr_reg;
            wr_cur   = wr_addr_reg;
            trs_cur  = tile_row_start_reg;
            btr_cur  = tile_row_bytes_reg;
            br_cur   = tiles_row_bytes_reg;
            tc_cur   = tile_col_reg;
        end
        if (br_cur == '0) begin
            wr_cur  = ADDR_WIDTH'(buffer_base);
            trs_cur = ADDR_WIDTH'(buffer_base);
        end

        result.src_addr   = out32(ADDR_WIDTH'(derived.src_base) + ta_cur);
        result.dst_addr   = out32(wr_cur);
        result.push_tiles = 1'b0;
        result.image_last = 1'b0;

        nb                   = {1'b0, br_cur} + 25'(derived.stick);
        tiles_row_bytes_next = nb[23:0];
        tile_row_bytes_next  = btr_cur;
        tile_col_next        = tc_cur;
        wr_addr_next         = wr_cur;
        tile_row_start_next  = trs_cur;
        if (({1'b0, btr_cur} + 8'(derived.stick)) < 8'(TILE_ROW_BYTES)) begin
            tile_row_bytes_next = btr_cur + derived.stick;
            wr_addr_next        = wr_cur + ADDR_WIDTH'(derived.stick);
        end else if (({1'b0, tc_cur} + 9'd1) < derived.ntc) begin
            wr_addr_next        = wr_cur + ADDR_WIDTH'(derived.stick) + ADDR_WIDTH'(TILE_JUMP);
            tile_row_bytes_next = '0;
            tile_col_next       = tc_cur + 8'd1;
        end else if (nb < 25'(derived.row_total)) begin
            tile_row_start_next = trs_cur + ADDR_WIDTH'(TILE_ROW_BYTES);
            wr_addr_next        = trs_cur + ADDR_WIDTH'(TILE_ROW_BYTES);
            tile_col_next       = '0;
            tile_row_bytes_next = '0;
        end else begin
            result.push_tiles    = 1'b1;
            tile_col_next        = '0;
            tile_row_bytes_next  = '0;
            tiles_row_bytes_next = '0;
        end

        row_index_next    = row_cur;
        col_index_next    = col_cur;
        tap_row_next      = trow_cur;
        tap_col_next      = tcol_cur;
        image_offset_next = io_cur;
        win_row_addr_next = wra_cur;
        win_addr_next     = wa_cur;
        tap_row_addr_next = tra_cur;
        tap_addr_next     = ta_cur;
        if (({1'b0, tcol_cur} + 5'd1) < derived.fc) begin
            tap_col_next  = tcol_cur + 4'd1;
            tap_addr_next = ta_cur + ADDR_WIDTH'(derived.stick);
        end else begin
            tap_col_next = '0;
            if (({1'b0, trow_cur} + 5'd1) < derived.fr) begin
                tap_row_next      = trow_cur + 4'd1;
                tap_row_addr_next = tra_cur + ADDR_WIDTH'(derived.row_pitch);
            end else begin
                tap_row_next = '0;
                if ((14'(col_cur) + 14'(derived.sc) + 14'(derived.fc)) <= 14'(derived.iw)) begin
                    col_index_next = col_cur + 12'(derived.sc);
                    win_addr_next  = wa_cur + ADDR_WIDTH'(derived.sc_stick);
                end else begin
                    col_index_next = '0;
                    if ((14'(row_cur) + 14'(derived.sr) + 14'(derived.fr))
                            <= 14'(derived.ih)) begin
                        row_index_next    = row_cur + 12'(derived.sr);
                        win_row_addr_next = wra_cur + ADDR_WIDTH'(derived.sr_pitch);
                    end else begin
                        row_index_next    = '0;
                        result.image_last = 1'b1;
                        image_offset_next = io_cur + ADDR_WIDTH'(derived.img_pitch);
                        win_row_addr_next = io_cur + ADDR_WIDTH'(derived.img_pitch);
                    end
                    win_addr_next = win_row_addr_next;
                end
                tap_row_addr_next = win_addr_next;
            end
            tap_addr_next = tap_row_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
        end else if (accept) begin
            started_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            row_index_reg       <= row_index_next;
            col_index_reg       <= col_index_next;
            tap_row_reg         <= tap_row_next;
            tap_col_reg         <= tap_col_next;
            image_offset_reg    <= image_offset_next;
            win_row_addr_reg    <= win_row_addr_next;
            win_addr_reg        <= win_addr_next;
            tap_row_addr_reg    <= tap_row_addr_next;
            tap_addr_reg        <= tap_addr_next;
            wr_addr_reg         <= wr_addr_next;
            tile_row_start_reg  <= tile_row_start_next;
            tile_row_bytes_reg  <= tile_row_bytes_next;
            tiles_row_bytes_reg <= tiles_row_bytes_next;
            tile_col_reg        <= tile_col_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.push_tiles |=> tiles_row_bytes_reg == '0)
        else $error("Row of tiles was pushed but its byte count did not clear.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.image_last |=> row_index_reg == '0 && col_index_reg == '0
            && tap_row_reg == '0 && tap_col_reg == '0)
        else $error("Walk did not return to the first window after the last read of an image.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> started_reg)
        else $error("Walk not marked started after an accepted request.");

endmodule
